// File: hw/rtl/sau_pkg.sv
// sau_pkg: shared widths, operation and status codes, controller states and
// the divider result record for the stack arithmetic unit
// no dependencies
package sau_pkg;

  localparam int WORD_W          = 32;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 7;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_res_t;

endpackage

// File: hw/rtl/stack_arithmetic_unit.sv
// stack_arithmetic_unit: top level of the stack machine execution unit
// depends on sau_pkg and sau_div
//
// Executes one stack operation per input item and returns one result item.
// The operation code arrives on s_tuser (0 push, 1 add, 2 sub, 3 mul, 4 div,
// 5 mod, 6 and 7 do nothing); a push takes its word from s_tdata. The
// arithmetic operations pop the top two entries and push (second op top),
// wrapping to 32 bits; div and mod truncate toward zero. Each result gives a
// status (0 ok, 1 fewer than two entries, 2 division by zero, 3 push onto a
// full stack), the top of stack afterwards (zero when empty) and the depth.
// On any error the stack is left as it was. One item is worked on at a time:
// push, unused codes, a full stack and a short stack go straight to the
// result, add, sub, mul and division by zero first pass an execute step, and
// div and mod also wait on the one-bit-per-cycle divider. The stack words
// live in a single-port-write synchronous memory; the top entry is also held
// in a register, so every operation needs only one memory read (the second
// entry), issued while the block waits for an item. A finished result sits
// in the output register, so the next item is taken while it waits.
module stack_arithmetic_unit
  import sau_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]  s_tuser,   // [2:0] op
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [1:0] status, [33:2] top_value, [40:34] depth, rest zero
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t state;
  state_t state_next;

  // stack memory, read address always the second entry
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  // control state
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [WORD_W-1:0]   top;
  logic [WORD_W-1:0]   top_next;

  // item in flight
  logic [OP_W-1:0]     op_q;
  logic [WORD_W-1:0]   result;
  logic [STATUS_W-1:0] status_q;

  logic                accept;
  logic                commit;
  logic                div_start;
  logic                is_arith;
  logic                op_arith_q;
  logic                is_full;
  logic                is_short;
  div_res_t            div_res;

  // output register
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0]   out_top;
  logic [DEPTH_W-1:0]  out_depth;

  assign accept     = s_tvalid && s_tready;
  assign is_arith   = (s_tuser inside {[OP_ADD:OP_MOD]});
  assign op_arith_q = (op_q inside {[OP_ADD:OP_MOD]});
  assign is_full    = (count == CW'(STACK_DEPTH));
  assign is_short   = (count < CW'(2));
  assign rd_addr    = AW'(count - CW'(2));

  // next state and handshake control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (is_arith && !is_short) begin
            state_next = S_EXEC;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_EXEC: begin
        if ((op_q == OP_DIV || op_q == OP_MOD) && top != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // write-back decision at commit
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = rd_addr;
    count_next = count;
    top_next   = top;
    if (status_q == ST_OK) begin
      if (op_q == OP_PUSH) begin
        wr_en      = 1'b1;
        wr_addr    = AW'(count);
        count_next = count + CW'(1);
        top_next   = result;
      end else if (op_arith_q) begin
        wr_en      = 1'b1;
        count_next = count - CW'(1);
        top_next   = result;
      end
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      stack_mem[wr_addr] <= result;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      top <= top_next;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q   <= s_tuser;
          result <= s_tdata;
          if (s_tuser == OP_PUSH && is_full) begin
            status_q <= ST_FULL;
          end else if (is_arith && is_short) begin
            status_q <= ST_SHORT;
          end else begin
            status_q <= ST_OK;
          end
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_ADD:  result <= rd_data + top;
          OP_SUB:  result <= rd_data - top;
          OP_MUL:  result <= rd_data * top;
          default: begin
            if (top == '0) begin
              status_q <= ST_DIVZERO;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_res.done) begin
          result <= (op_q == OP_DIV) ? div_res.quot : div_res.rem;
        end
      end
      default: begin
      end
    endcase
  end

  sau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (top),
    .res      (div_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= status_q;
      out_top    <= (count_next == '0) ? '0 : top_next;
      out_depth  <= DEPTH_W'(count_next);
    end
  end

  assign m_tdata = {7'd0, out_depth, out_top, out_status};

endmodule

// File: hw/rtl/sau_div.sv
// sau_div: iterative signed divider, one quotient bit per cycle,
// truncating toward zero with the remainder taking the dividend's sign
// depends on sau_pkg
module sau_div
  import sau_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_res_t          res
);

  localparam int STEP_W = $clog2(WORD_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic              neg_q;
  logic              neg_r;

  logic [WORD_W:0]   rem_shift;
  logic [WORD_W:0]   diff;

  assign rem_shift = {rem, quo[WORD_W-1]};
  assign diff      = rem_shift - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(WORD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dvs   <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      rem   <= '0;
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy) begin
      // restoring step
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.quot = neg_q ? (WORD_W'(0) - quo) : quo;
  assign res.rem  = neg_r ? (WORD_W'(0) - rem) : rem;

endmodule
